@@ rtl/tpc_pkg.sv @@
// Shared constants for the throttle position PI controller.
// No dependencies; the interfaces and the top level import it.
package tpc_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int DUTY_MAX_DEF    = 3599;
	localparam int TICK_BITS_DEF   = 16;

	localparam int TARGET_W    = 15;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EMA_WEIGHT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_DIF = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OPEN_DIF   = 3'd5;

	localparam logic [23:0] PROP_GAIN_RST  = 24'd46080;
	localparam logic [23:0] INTEG_GAIN_RST = 24'd51200;
	localparam logic [23:0] DERIV_GAIN_RST = 24'd0;
	localparam logic [8:0]  EMA_WEIGHT_RST = 9'd179;
	localparam logic [12:0] CLOSED_DIF_RST = 13'd0;
	localparam logic [12:0] OPEN_DIF_RST   = 13'd4095;

	localparam logic [14:0] FULL_Q         = 15'd25600;
	localparam logic [14:0] RISE_POS_MIN   = 15'd1280;
	localparam logic [23:0] SETTLE_LIMIT   = 24'd65536;
	localparam logic [47:0] INTEG_LIMIT    = 48'd9502720000;

	// Reciprocals for the constant divisions: x / 20 = (x * AVG_RECIP) >> AVG_SHIFT
	// for x below 2^30, x / 100 = (x * DUTY_RECIP) >> DUTY_SHIFT for x below 2^23.
	localparam logic signed [31:0] AVG_RECIP  = 32'sd214748365;
	localparam int                 AVG_SHIFT  = 32;
	localparam logic signed [31:0] DUTY_RECIP = 32'sd10737419;
	localparam int                 DUTY_SHIFT = 30;

endpackage

@@ rtl/tpc_if.sv @@
// Valid/ready channels of the throttle position PI controller.
// Depends on tpc_pkg for the default widths.
interface tpc_in_if import tpc_pkg::*; #(parameter int SB = SAMPLE_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [SB-1:0]       sensor_one;
	logic [SB-1:0]       sensor_two;
	logic [TARGET_W-1:0] target_percent;
	modport source(output valid, sensor_one, sensor_two, target_percent, input ready);
	modport sink(input valid, sensor_one, sensor_two, target_percent, output ready);
endinterface

interface tpc_out_if import tpc_pkg::*; #(parameter int DW = $clog2(DUTY_MAX_DEF + 1));
	logic                valid;
	logic                ready;
	logic [DW-1:0]       pwm_duty;
	logic [TARGET_W-1:0] position_percent;
	logic signed [15:0]  control_error;
	logic [TARGET_W-1:0] mean_abs_error;
	logic [15:0]         overshoot_ratio;
	logic [15:0]         rise_ticks;
	logic [15:0]         settle_ticks;
	logic                rise_found;
	logic                settle_found;
	modport source(output valid, pwm_duty, position_percent, control_error, mean_abs_error,
		overshoot_ratio, rise_ticks, settle_ticks, rise_found, settle_found, input ready);
	modport sink(input valid, pwm_duty, position_percent, control_error, mean_abs_error,
		overshoot_ratio, rise_ticks, settle_ticks, rise_found, settle_found, output ready);
endinterface

@@ rtl/throttle_position_pi_controller.sv @@
// Throttle position PI controller: each accepted input beat runs through the sequencer to one
// result beat; both divisions and the upper integral products can be skipped.
// A new input beat is taken only in the idle state, after the last result is loaded, plus any stall on the result side.
// The sequencer uses one shared 32x32 multiplier and a bit-serial divider that produces one
// quotient bit per cycle, for the position and the overshoot.
// Asynchronous active-low reset clears filters, integrator, metrics and loads the defaults.
module throttle_position_pi_controller import tpc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int DUTY_MAX    = DUTY_MAX_DEF,
	parameter int TICK_BITS   = TICK_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	tpc_in_if.sink                 in_ch,
	tpc_out_if.source              out_ch
);

	// Filter state is Q(SAMPLE_BITS).8; the position numerator needs a few extra bits.
	localparam int FW   = SAMPLE_BITS + 8;
	localparam int NW   = ((FW + 1 > 21) ? FW + 1 : 21) + 1;
	localparam int DIVW = (NW + 6 > 28) ? NW + 6 : 28;
	localparam int CW   = $clog2(DIVW);
	localparam int DW   = $clog2(DUTY_MAX + 1);
	localparam logic [39:0] DUTY_CEIL = 40'(100 * (DUTY_MAX + 1));

	// Sequencer codes.
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_EM0   = 5'd1;
	localparam logic [4:0] ST_EM1   = 5'd2;
	localparam logic [4:0] ST_EM2   = 5'd3;
	localparam logic [4:0] ST_EM3   = 5'd4;
	localparam logic [4:0] ST_EM4   = 5'd5;
	localparam logic [4:0] ST_POS0  = 5'd6;
	localparam logic [4:0] ST_POS1  = 5'd7;
	localparam logic [4:0] ST_POS2  = 5'd8;
	localparam logic [4:0] ST_POS3  = 5'd9;
	localparam logic [4:0] ST_ERR   = 5'd10;
	localparam logic [4:0] ST_AF0   = 5'd11;
	localparam logic [4:0] ST_AF1   = 5'd12;
	localparam logic [4:0] ST_OV0   = 5'd13;
	localparam logic [4:0] ST_OV1   = 5'd14;
	localparam logic [4:0] ST_MET   = 5'd15;
	localparam logic [4:0] ST_C0    = 5'd16;
	localparam logic [4:0] ST_C1    = 5'd17;
	localparam logic [4:0] ST_C2    = 5'd18;
	localparam logic [4:0] ST_C3    = 5'd19;
	localparam logic [4:0] ST_C4    = 5'd20;
	localparam logic [4:0] ST_C5    = 5'd21;
	localparam logic [4:0] ST_C6    = 5'd22;
	localparam logic [4:0] ST_C7    = 5'd23;
	localparam logic [4:0] ST_DUTY0 = 5'd24;
	localparam logic [4:0] ST_DUTY1 = 5'd25;
	localparam logic [4:0] ST_FIN   = 5'd26;
	localparam logic [4:0] ST_DIV   = 5'd27;
	localparam logic [4:0] ST_AF2   = 5'd28;

	// Configuration registers.
	logic [23:0]        kp_q, ki_q, kd_q;
	logic [8:0]         weight_q;
	logic signed [12:0] closed_q, open_q;

	// Per-tick working registers.
	logic [4:0]             state_q, ret_q;
	logic [SAMPLE_BITS-1:0] raw1_q, raw2_q;
	logic [14:0]            tgt_q;
	logic signed [63:0]     prod_q, work_q;
	logic signed [NW-1:0]   num_q;
	logic signed [13:0]     span_q;
	logic [14:0]            pos_q;
	logic signed [16:0]     e_q;
	logic [15:0]            over_q;
	logic signed [55:0]     sum_q;
	logic [47:0]            it_q;

	// Divider.
	logic [DIVW-1:0] quo_q;
	logic [15:0]     rem_q, dvs_q;
	logic [CW-1:0]   cnt_q;

	// Controller state kept across ticks.
	logic [FW-1:0]          f1_q, f2_q;
	logic signed [39:0]     acc_q;
	logic signed [16:0]     prev_q, low_q;
	logic [23:0]            avg_q;
	logic [TICK_BITS-1:0]   ticks_q, rise_q, settle_q;
	logic                   rise_flag_q, settle_flag_q;

	// Result register.
	logic                out_valid_q;
	logic [DW-1:0]       duty_q, o_duty_q;
	logic [14:0]         o_pos_q, o_mae_q;
	logic [15:0]         o_err_q, o_over_q, o_rise_q, o_settle_q;
	logic                o_rf_q, o_sf_q;

	// Combinational helpers.
	logic [8:0]            w;
	logic signed [31:0]    mul_a, mul_b;
	logic [NW-1:0]         num_abs;
	logic [13:0]           span_abs;
	logic [16:0]           e_abs;
	logic [16:0]           low_neg;
	logic [16:0]           rem_sh;
	logic                  q_bit;
	logic                  tgt_zero;
	logic                  sign_change;
	logic [TICK_BITS-1:0]  ticks_eff, rise_next;
	logic                  rf_eff, sf_eff, rise_hit, rf_next, settle_hit;
	logic signed [40:0]    acc_sum;
	logic signed [39:0]    acc_next;
	logic signed [17:0]    de;
	logic [23:0]           hi_sat;
	logic [47:0]           it_clamped;
	logic [39:0]           sum_hi;
	logic [32:0]           rise_wide, settle_wide;

	assign w        = (weight_q > 9'd256) ? 9'd256 : weight_q;
	assign num_abs  = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
	assign span_abs = span_q[13] ? 14'(-span_q) : 14'(span_q);
	assign e_abs    = e_q[16] ? 17'(-e_q) : 17'(e_q);
	assign low_neg  = 17'(-low_q);
	assign rem_sh   = {rem_q, quo_q[DIVW-1]};
	assign q_bit    = (rem_sh >= {1'b0, dvs_q});
	assign tgt_zero = (tgt_q == 15'd0);
	assign de       = 18'(e_q) - 18'(prev_q);
	assign sum_hi   = 40'(sum_q[55:16]);

	// The ki * acc upper partial product only matters up to the clamp.
	assign hi_sat     = (prod_q >= 64'sd8388608) ? 24'd8388608 : {1'b0, prod_q[22:0]};
	assign it_clamped = (it_q > INTEG_LIMIT) ? INTEG_LIMIT : it_q;

	// Metric bookkeeping: a zero target clears the metrics before the capture checks.
	assign sign_change = ((prev_q < 0) && (e_q > 0)) || ((prev_q > 0) && (e_q < 0));
	assign rf_eff      = tgt_zero ? 1'b0 : rise_flag_q;
	assign sf_eff      = tgt_zero ? 1'b0 : settle_flag_q;
	assign ticks_eff   = tgt_zero ? '0 : ((ticks_q != '1) ? ticks_q + 1'b1 : ticks_q);
	assign rise_hit    = sign_change && !rf_eff && (pos_q > RISE_POS_MIN);
	assign rf_next     = rf_eff | rise_hit;
	assign rise_next   = rise_hit ? ticks_eff : (tgt_zero ? '0 : rise_q);
	assign settle_hit  = (avg_q <= SETTLE_LIMIT) && rf_next && !sf_eff;

	// Integrator with saturation at the 40-bit range.
	assign acc_sum  = 41'(acc_q) + 41'(e_q);
	always_comb begin
		if (acc_sum > 41'sh07F_FFFF_FFFF) begin
			acc_next = 40'sh7F_FFFF_FFFF;
		end else if (acc_sum < -41'sh080_0000_0000) begin
			acc_next = -40'sh80_0000_0000;
		end else begin
			acc_next = acc_sum[39:0];
		end
	end

	assign rise_wide   = 33'(rise_q);
	assign settle_wide = 33'(settle_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EM0: begin
				mul_a = 32'($signed({1'b0, w}));
				mul_b = 32'($signed({1'b0, raw1_q, 8'd0}));
			end
			ST_EM1: begin
				mul_a = 32'($signed({1'b0, 9'(9'd256 - w)}));
				mul_b = 32'($signed({1'b0, f1_q}));
			end
			ST_EM2: begin
				mul_a = 32'($signed({1'b0, w}));
				mul_b = 32'($signed({1'b0, raw2_q, 8'd0}));
			end
			ST_EM3: begin
				mul_a = 32'($signed({1'b0, 9'(9'd256 - w)}));
				mul_b = 32'($signed({1'b0, f2_q}));
			end
			ST_POS1: begin
				mul_a = 32'($signed({1'b0, num_abs}));
				mul_b = 32'sd100;
			end
			ST_AF1: begin
				mul_a = $signed({1'b0, work_q[30:0]});
				mul_b = AVG_RECIP;
			end
			ST_C0: begin
				mul_a = 32'(e_q);
				mul_b = 32'sd100;
			end
			ST_C1: begin
				mul_a = 32'($signed({1'b0, kp_q}));
				mul_b = prod_q[31:0];
			end
			ST_C2: begin
				mul_a = 32'(de);
				mul_b = 32'sd10000;
			end
			ST_C3: begin
				mul_a = 32'($signed({1'b0, kd_q}));
				mul_b = prod_q[31:0];
			end
			ST_C4: begin
				mul_a = 32'($signed({1'b0, ki_q}));
				mul_b = 32'($signed({1'b0, acc_q[21:0]}));
			end
			ST_C5: begin
				mul_a = 32'($signed({1'b0, ki_q}));
				mul_b = 32'($signed({1'b0, acc_q[38:22]}));
			end
			ST_DUTY0: begin
				mul_a = $signed({1'b0, sum_hi[30:0]});
				mul_b = DUTY_RECIP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Configuration writes; indexes past the list fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= PROP_GAIN_RST;
			ki_q     <= INTEG_GAIN_RST;
			kd_q     <= DERIV_GAIN_RST;
			weight_q <= EMA_WEIGHT_RST;
			closed_q <= CLOSED_DIF_RST;
			open_q   <= OPEN_DIF_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PROP_GAIN:  kp_q     <= cfg_data;
				REG_INTEG_GAIN: ki_q     <= cfg_data;
				REG_DERIV_GAIN: kd_q     <= cfg_data;
				REG_EMA_WEIGHT: weight_q <= cfg_data[8:0];
				REG_CLOSED_DIF: closed_q <= cfg_data[12:0];
				REG_OPEN_DIF:   open_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// The multiplier runs every cycle; its product is read one state later.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ret_q         <= ST_IDLE;
			raw1_q        <= '0;
			raw2_q        <= '0;
			tgt_q         <= '0;
			work_q        <= '0;
			num_q         <= '0;
			span_q        <= '0;
			pos_q         <= '0;
			e_q           <= '0;
			over_q        <= '0;
			sum_q         <= '0;
			it_q          <= '0;
			quo_q         <= '0;
			rem_q         <= '0;
			dvs_q         <= '0;
			cnt_q         <= '0;
			f1_q          <= '0;
			f2_q          <= '0;
			acc_q         <= '0;
			prev_q        <= '0;
			low_q         <= '0;
			avg_q         <= '0;
			ticks_q       <= '0;
			rise_q        <= '0;
			settle_q      <= '0;
			rise_flag_q   <= 1'b0;
			settle_flag_q <= 1'b0;
			duty_q        <= '0;
			out_valid_q   <= 1'b0;
			o_duty_q      <= '0;
			o_pos_q       <= '0;
			o_err_q       <= '0;
			o_mae_q       <= '0;
			o_over_q      <= '0;
			o_rise_q      <= '0;
			o_settle_q    <= '0;
			o_rf_q        <= 1'b0;
			o_sf_q        <= 1'b0;
		end else begin
			// A result leaving while the next one is loaded keeps the valid bit high.
			if (out_valid_q && out_ch.ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						raw1_q  <= in_ch.sensor_one;
						raw2_q  <= in_ch.sensor_two;
						tgt_q   <= (in_ch.target_percent > FULL_Q) ? FULL_Q : in_ch.target_percent;
						state_q <= ST_EM0;
					end
				end
				// Two EMA updates, each the sum of two products.
				ST_EM0: state_q <= ST_EM1;
				ST_EM1: begin
					work_q  <= prod_q;
					state_q <= ST_EM2;
				end
				ST_EM2: begin
					f1_q    <= FW'((work_q + prod_q) >>> 8);
					state_q <= ST_EM3;
				end
				ST_EM3: begin
					work_q  <= prod_q;
					state_q <= ST_EM4;
				end
				ST_EM4: begin
					f2_q    <= FW'((work_q + prod_q) >>> 8);
					state_q <= ST_POS0;
				end
				ST_POS0: begin
					num_q   <= NW'($signed({1'b0, f1_q})) - NW'($signed({1'b0, f2_q}))
						- NW'($signed({closed_q, 8'd0}));
					span_q  <= 14'(open_q) - 14'(closed_q);
					state_q <= ST_POS1;
				end
				ST_POS1: state_q <= ST_POS2;
				ST_POS2: begin
					// A zero span, a zero numerator or opposite signs all land on zero.
					if ((span_q == 14'sd0) || (num_q == '0) || (num_q[NW-1] != span_q[13])) begin
						pos_q   <= '0;
						state_q <= ST_ERR;
					end else begin
						quo_q   <= prod_q[DIVW-1:0];
						rem_q   <= '0;
						dvs_q   <= 16'(span_abs);
						cnt_q   <= '0;
						ret_q   <= ST_POS3;
						state_q <= ST_DIV;
					end
				end
				ST_POS3: begin
					pos_q   <= (quo_q > DIVW'(FULL_Q)) ? FULL_Q : quo_q[14:0];
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					e_q     <= $signed({2'b0, tgt_q}) - $signed({2'b0, pos_q});
					state_q <= ST_AF0;
				end
				ST_AF0: begin
					// 19 * avg is built from shifts: 16a + 2a + a.
					work_q  <= 64'({e_abs[15:0], 8'd0}) + (64'(avg_q) << 4)
						+ (64'(avg_q) << 1) + 64'(avg_q);
					state_q <= ST_AF1;
					if (e_q < low_q) begin
						low_q <= e_q;
					end
				end
				// The division by 20 is a reciprocal product on the shared multiplier.
				ST_AF1: state_q <= ST_AF2;
				ST_AF2: begin
					avg_q   <= prod_q[AVG_SHIFT +: 24];
					state_q <= ST_OV0;
				end
				ST_OV0: begin
					if (tgt_zero) begin
						over_q  <= '0;
						state_q <= ST_MET;
					end else begin
						quo_q   <= DIVW'({low_neg, 8'd0});
						rem_q   <= '0;
						dvs_q   <= 16'(tgt_q);
						cnt_q   <= '0;
						ret_q   <= ST_OV1;
						state_q <= ST_DIV;
					end
				end
				ST_OV1: begin
					over_q  <= (quo_q > DIVW'(16'hFFFF)) ? 16'hFFFF : quo_q[15:0];
					state_q <= ST_MET;
				end
				ST_MET: begin
					if (tgt_zero) begin
						low_q <= '0;
					end
					ticks_q       <= ticks_eff;
					rise_q        <= rise_next;
					rise_flag_q   <= rf_next;
					settle_q      <= settle_hit ? ticks_eff : (tgt_zero ? '0 : settle_q);
					settle_flag_q <= sf_eff | settle_hit;
					acc_q         <= tgt_zero ? '0 : acc_next;
					state_q       <= ST_C0;
				end
				// Control law: P, then D, then the clamped integral term.
				ST_C0: state_q <= ST_C1;
				ST_C1: state_q <= ST_C2;
				ST_C2: begin
					sum_q   <= prod_q[55:0];
					state_q <= ST_C3;
				end
				ST_C3: state_q <= ST_C4;
				ST_C4: begin
					sum_q <= sum_q + prod_q[55:0];
					if (acc_q[39] || (acc_q == 40'sd0) || (ki_q == 24'd0)) begin
						it_q    <= '0;
						state_q <= ST_C7;
					end else begin
						state_q <= ST_C5;
					end
				end
				ST_C5: begin
					it_q    <= prod_q[47:0];
					state_q <= ST_C6;
				end
				ST_C6: begin
					it_q    <= it_q + (48'(hi_sat) << 22);
					state_q <= ST_C7;
				end
				ST_C7: begin
					sum_q   <= sum_q + 56'(it_clamped);
					state_q <= ST_DUTY0;
				end
				// The division by 100 is a reciprocal product on the shared multiplier.
				ST_DUTY0: begin
					if (sum_q[55] || tgt_zero) begin
						duty_q  <= '0;
						state_q <= ST_FIN;
					end else if (sum_hi >= DUTY_CEIL) begin
						duty_q  <= DW'(DUTY_MAX);
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DUTY1;
					end
				end
				ST_DUTY1: begin
					duty_q  <= prod_q[DUTY_SHIFT +: DW];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						o_duty_q    <= duty_q;
						o_pos_q     <= pos_q;
						o_err_q     <= e_q[15:0];
						o_mae_q     <= avg_q[22:8];
						o_over_q    <= over_q;
						o_rise_q    <= (rise_wide > 33'd65535) ? 16'hFFFF : rise_wide[15:0];
						o_settle_q  <= (settle_wide > 33'd65535) ? 16'hFFFF : settle_wide[15:0];
						o_rf_q      <= rise_flag_q;
						o_sf_q      <= settle_flag_q;
						prev_q      <= e_q;
						state_q     <= ST_IDLE;
					end
				end
				// Restoring divider, one quotient bit per cycle, returning to ret_q.
				ST_DIV: begin
					rem_q <= q_bit ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
					quo_q <= {quo_q[DIVW-2:0], q_bit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIVW - 1)) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready             = (state_q == ST_IDLE);
	assign out_ch.valid            = out_valid_q;
	assign out_ch.pwm_duty         = o_duty_q;
	assign out_ch.position_percent = o_pos_q;
	assign out_ch.control_error    = o_err_q;
	assign out_ch.mean_abs_error   = o_mae_q;
	assign out_ch.overshoot_ratio  = o_over_q;
	assign out_ch.rise_ticks       = o_rise_q;
	assign out_ch.settle_ticks     = o_settle_q;
	assign out_ch.rise_found       = o_rf_q;
	assign out_ch.settle_found     = o_sf_q;

endmodule
